// File: hw/rtl/bep_pkg.sv
// bep_pkg: constants, phase codes and result type of the bmp envelope header parser
// no dependencies; used by the top level and the testbench
package bep_pkg;

  // longest name kept is NAME_MAX_BYTES-1 bytes
  localparam int NAME_MAX_BYTES = 32;
  localparam logic [15:0] NAME_KEEP = 16'(NAME_MAX_BYTES - 1);

  localparam logic [17:0] OFF_MAX = 18'h3FFFF;

  // parse phases
  localparam logic [4:0] PH_START    = 5'd0;
  localparam logic [4:0] PH_TEXT     = 5'd1;
  localparam logic [4:0] PH_MAGIC    = 5'd2;
  localparam logic [4:0] PH_VER      = 5'd3;
  localparam logic [4:0] PH_SKIP     = 5'd4;
  localparam logic [4:0] PH_FLAGS    = 5'd5;
  localparam logic [4:0] PH_TYPE     = 5'd6;
  localparam logic [4:0] PH_SEC      = 5'd7;
  localparam logic [4:0] PH_USEC     = 5'd8;
  localparam logic [4:0] PH_CHASH    = 5'd9;
  localparam logic [4:0] PH_CLEN     = 5'd10;
  localparam logic [4:0] PH_CNAME    = 5'd11;
  localparam logic [4:0] PH_RHASH    = 5'd12;
  localparam logic [4:0] PH_RADDR    = 5'd13;
  localparam logic [4:0] PH_RLEN     = 5'd14;
  localparam logic [4:0] PH_RNAME    = 5'd15;
  localparam logic [4:0] PH_ROWS     = 5'd16;
  localparam logic [4:0] PH_RAW      = 5'd17;
  localparam logic [4:0] PH_TEXTDONE = 5'd18;
  localparam logic [4:0] PH_KEPT     = 5'd19;
  localparam logic [4:0] PH_UNWANTED = 5'd20;

  // result kinds
  localparam logic [1:0] KIND_CNAME   = 2'd0;
  localparam logic [1:0] KIND_RNAME   = 2'd1;
  localparam logic [1:0] KIND_RADDR   = 2'd2;
  localparam logic [1:0] KIND_VERDICT = 2'd3;

  // verdicts
  localparam logic [2:0] VERDICT_RAW      = 3'd0;
  localparam logic [2:0] VERDICT_TEXT     = 3'd1;
  localparam logic [2:0] VERDICT_KEPT     = 3'd2;
  localparam logic [2:0] VERDICT_UNWANTED = 3'd3;
  localparam logic [2:0] VERDICT_TRUNC    = 3'd4;

  // header bytes
  localparam logic [7:0] CHAR_V        = 8'h56;
  localparam logic [7:0] CHAR_NL       = 8'h0A;
  localparam logic [3:0][7:0] MAGIC    = {8'h50, 8'h4D, 8'h42, 8'h4F}; // "OBMP", [0] first
  localparam logic [7:0] VER_MAJOR     = 8'd1;
  localparam logic [7:0] VER_MINOR     = 8'd7;
  localparam int         FLAG_ROUTER   = 7;  // 0x80
  localparam int         FLAG_V6       = 6;  // 0x40
  localparam logic [7:0] OBJ_TYPE      = 8'd12;
  localparam logic [15:0] ADDR_V4_LEN  = 16'd4;
  localparam logic [15:0] ADDR_LEN     = 16'd16;
  localparam logic [15:0] HASH_LEN     = 16'd16;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  out_byte;
    logic [2:0]  verdict;
    logic [17:0] header_length;
    logic [31:0] time_seconds;
    logic [31:0] time_microseconds;
    logic        router_is_ipv6;
    logic [15:0] collector_name_length;
    logic [15:0] router_name_length;
    logic        last_of_run;
  } result_t;

endpackage

// File: hw/rtl/bep_channel_if.sv
// bep_in_if and bep_out_if: valid/ready channels of the envelope header parser
// no dependencies
interface bep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_buffer;

  modport source(output valid, output in_byte, output end_of_buffer, input ready);
  modport sink(input valid, input in_byte, input end_of_buffer, output ready);
endinterface

interface bep_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  out_byte;
  logic [2:0]  verdict;
  logic [17:0] header_length;
  logic [31:0] time_seconds;
  logic [31:0] time_microseconds;
  logic        router_is_ipv6;
  logic [15:0] collector_name_length;
  logic [15:0] router_name_length;
  logic        last_of_run;

  modport source(output valid, output result_kind, output out_byte, output verdict,
                 output header_length, output time_seconds, output time_microseconds,
                 output router_is_ipv6, output collector_name_length,
                 output router_name_length, output last_of_run, input ready);
  modport sink(input valid, input result_kind, input out_byte, input verdict,
               input header_length, input time_seconds, input time_microseconds,
               input router_is_ipv6, input collector_name_length,
               input router_name_length, input last_of_run, output ready);
endinterface

// File: hw/rtl/bmp_envelope_header_parser_top.sv
// bmp_envelope_header_parser_top: byte-serial classifier of the envelope in front of a bmp message
// depends on bep_pkg and on bep_in_if / bep_out_if (bep_channel_if.sv)
//
// Takes one buffer byte per request on in_if, with end_of_buffer on the last byte of the
// buffer. Each byte is parsed in the cycle it is accepted: the phase and field registers
// step, and the results it causes (a collector name, router name or router address byte,
// and on the last byte a verdict with header length and timestamps) go into a three-entry
// result queue that feeds out_if one request per cycle while out_if is ready. The input
// is ready while the queue holds at most one result, so with out_if always ready the block
// runs at one byte per cycle, and a byte that causes two results (a name or address byte
// on the final byte of a buffer) holds the input off while the queue drains. After the
// verdict all parse state returns to its reset value, ready for the next buffer.
module bmp_envelope_header_parser_top (
  input  logic      clk,
  input  logic      rst_n,
  bep_in_if.sink    in_if,
  bep_out_if.source out_if
);

  // parse state
  logic [4:0]  phase_r, phase_nxt;
  logic [15:0] fc_r, fc_nxt;         // byte index within the current field
  logic [17:0] off_r, off_nxt;       // buffer offset, saturating
  logic [1:0]  nl_r, nl_nxt;         // newlines in a row in a text header
  logic [7:0]  hf_r, hf_nxt;         // major version, then header flags
  logic [31:0] sec_r, sec_nxt;
  logic [31:0] usec_r, usec_nxt;
  logic [15:0] clen_r, clen_nxt;
  logic [15:0] rlen_r, rlen_nxt;

  // result queue, head at entry 0
  bep_pkg::result_t q_r [3];
  bep_pkg::result_t q_nxt [3];
  bep_pkg::result_t q_sh [3];
  logic [1:0] cnt_r, cnt_nxt;

  logic       acc;
  logic       pop;
  logic [7:0] b;
  logic       eob;
  logic       given;
  logic       adv;
  logic       emit;
  logic [1:0] emit_kind;
  logic [15:0] fc_inc;
  logic [4:0]  ph_step;
  logic [2:0]  vd;
  logic [17:0] hl;
  logic        info;
  bep_pkg::result_t r_byte, r_verd, r0, r1;
  logic [1:0] npush;
  logic [1:0] base;

  // bytes in each fixed field; name fields take their declared lengths
  function automatic logic [15:0] phase_length(input logic [4:0] ph,
                                               input logic [15:0] cl,
                                               input logic [15:0] rl);
    logic [15:0] len;
    case (ph)
      bep_pkg::PH_MAGIC: len = 16'd4;
      bep_pkg::PH_VER:   len = 16'd2;
      bep_pkg::PH_SKIP:  len = 16'd6;
      bep_pkg::PH_FLAGS: len = 16'd1;
      bep_pkg::PH_TYPE:  len = 16'd1;
      bep_pkg::PH_SEC:   len = 16'd4;
      bep_pkg::PH_USEC:  len = 16'd4;
      bep_pkg::PH_CHASH: len = bep_pkg::HASH_LEN;
      bep_pkg::PH_CLEN:  len = 16'd2;
      bep_pkg::PH_CNAME: len = cl;
      bep_pkg::PH_RHASH: len = bep_pkg::HASH_LEN;
      bep_pkg::PH_RADDR: len = bep_pkg::ADDR_LEN;
      bep_pkg::PH_RLEN:  len = 16'd2;
      bep_pkg::PH_RNAME: len = rl;
      default:           len = 16'd4;
    endcase
    return len;
  endfunction

  assign b     = in_if.in_byte;
  assign eob   = in_if.end_of_buffer;
  // input stays open while the queue can take two more results
  assign in_if.ready = (cnt_r <= 2'd1);
  assign acc   = in_if.valid && in_if.ready;
  assign pop   = out_if.valid && out_if.ready;
  // header outcome already decided
  assign given = (phase_r >= bep_pkg::PH_RAW);

  // per-byte parse step
  always_comb begin
    phase_nxt = phase_r;
    fc_nxt    = fc_r;
    off_nxt   = off_r;
    nl_nxt    = nl_r;
    hf_nxt    = hf_r;
    sec_nxt   = sec_r;
    usec_nxt  = usec_r;
    clen_nxt  = clen_r;
    rlen_nxt  = rlen_r;
    adv       = 1'b0;
    emit      = 1'b0;
    emit_kind = bep_pkg::KIND_CNAME;
    fc_inc    = fc_r + 16'd1;
    ph_step   = phase_r + 5'd1;

    // offset keeps counting through an unwanted header to give the buffer length
    if (!(given && phase_r != bep_pkg::PH_UNWANTED) && off_r < bep_pkg::OFF_MAX) begin
      off_nxt = off_r + 18'd1;
    end

    if (!given) begin
      case (phase_r)
        bep_pkg::PH_START: begin
          if (b == bep_pkg::CHAR_V) begin
            phase_nxt = bep_pkg::PH_TEXT;
            nl_nxt    = 2'd0;
          end else if (b == bep_pkg::MAGIC[0]) begin
            phase_nxt = bep_pkg::PH_MAGIC;
            fc_nxt    = 16'd1;
          end else begin
            phase_nxt = bep_pkg::PH_RAW;
          end
        end
        bep_pkg::PH_TEXT: begin
          // header ends on the byte after the blank line, which is payload
          if (nl_r >= 2'd2) begin
            phase_nxt = bep_pkg::PH_TEXTDONE;
            off_nxt   = off_r;
          end else begin
            nl_nxt = (b == bep_pkg::CHAR_NL) ? nl_r + 2'd1 : 2'd0;
          end
        end
        bep_pkg::PH_MAGIC: begin
          if (b != bep_pkg::MAGIC[fc_r[1:0]]) begin
            phase_nxt = bep_pkg::PH_RAW;
          end else begin
            adv = 1'b1;
          end
        end
        bep_pkg::PH_VER: begin
          if (fc_r == 16'd0) begin
            hf_nxt = b;
            adv    = 1'b1;
          end else if (hf_r != bep_pkg::VER_MAJOR || b != bep_pkg::VER_MINOR) begin
            phase_nxt = bep_pkg::PH_UNWANTED;
          end else begin
            hf_nxt = 8'd0;
            adv    = 1'b1;
          end
        end
        bep_pkg::PH_FLAGS: begin
          hf_nxt = b;
          if (!b[bep_pkg::FLAG_ROUTER]) begin
            phase_nxt = bep_pkg::PH_UNWANTED;
          end else begin
            adv = 1'b1;
          end
        end
        bep_pkg::PH_TYPE: begin
          if (b != bep_pkg::OBJ_TYPE) begin
            phase_nxt = bep_pkg::PH_UNWANTED;
          end else begin
            adv = 1'b1;
          end
        end
        bep_pkg::PH_SEC: begin
          sec_nxt = {sec_r[23:0], b};
          adv     = 1'b1;
        end
        bep_pkg::PH_USEC: begin
          usec_nxt = {usec_r[23:0], b};
          adv      = 1'b1;
        end
        bep_pkg::PH_CLEN: begin
          clen_nxt = {clen_r[7:0], b};
          adv      = 1'b1;
        end
        bep_pkg::PH_RLEN: begin
          rlen_nxt = {rlen_r[7:0], b};
          adv      = 1'b1;
        end
        bep_pkg::PH_CNAME: begin
          emit      = (fc_r < bep_pkg::NAME_KEEP);
          emit_kind = bep_pkg::KIND_CNAME;
          adv       = 1'b1;
        end
        bep_pkg::PH_RNAME: begin
          emit      = (fc_r < bep_pkg::NAME_KEEP);
          emit_kind = bep_pkg::KIND_RNAME;
          adv       = 1'b1;
        end
        bep_pkg::PH_RADDR: begin
          // ipv4 address sits in the first four bytes of the field
          emit      = hf_r[bep_pkg::FLAG_V6] || (fc_r < bep_pkg::ADDR_V4_LEN);
          emit_kind = bep_pkg::KIND_RADDR;
          adv       = 1'b1;
        end
        default: begin
          adv = 1'b1;
        end
      endcase
    end

    // field done: move on, skipping empty names
    if (adv) begin
      if (fc_inc < phase_length(phase_r, clen_nxt, rlen_nxt)) begin
        fc_nxt = fc_inc;
      end else begin
        fc_nxt = 16'd0;
        if (phase_r == bep_pkg::PH_ROWS) begin
          phase_nxt = bep_pkg::PH_KEPT;
        end else begin
          if (ph_step == bep_pkg::PH_CNAME && clen_nxt == 16'd0) begin
            ph_step = bep_pkg::PH_RHASH;
          end
          if (ph_step == bep_pkg::PH_RNAME && rlen_nxt == 16'd0) begin
            ph_step = bep_pkg::PH_ROWS;
          end
          phase_nxt = ph_step;
        end
      end
    end
  end

  // verdict from the state after this byte
  always_comb begin
    vd   = bep_pkg::VERDICT_TRUNC;
    hl   = 18'd0;
    info = 1'b0;
    if (off_nxt < 18'd4) begin
      vd = bep_pkg::VERDICT_RAW;
    end else if (phase_nxt inside {bep_pkg::PH_RAW, bep_pkg::PH_TEXT, bep_pkg::PH_START}) begin
      vd = bep_pkg::VERDICT_RAW;
    end else if (phase_nxt == bep_pkg::PH_TEXTDONE) begin
      vd = bep_pkg::VERDICT_TEXT;
      hl = off_nxt;
    end else if (phase_nxt == bep_pkg::PH_KEPT) begin
      vd   = bep_pkg::VERDICT_KEPT;
      hl   = off_nxt;
      info = 1'b1;
    end else if (phase_nxt == bep_pkg::PH_UNWANTED) begin
      vd = bep_pkg::VERDICT_UNWANTED;
      hl = off_nxt;
    end
  end

  // build the results of this byte
  always_comb begin
    r_byte = '0;
    r_byte.result_kind = emit_kind;
    r_byte.out_byte    = b;
    r_byte.last_of_run = !eob;

    r_verd = '0;
    r_verd.result_kind   = bep_pkg::KIND_VERDICT;
    r_verd.verdict       = vd;
    r_verd.header_length = hl;
    r_verd.last_of_run   = 1'b1;
    if (info) begin
      r_verd.time_seconds          = sec_nxt;
      r_verd.time_microseconds     = usec_nxt;
      r_verd.router_is_ipv6        = hf_nxt[bep_pkg::FLAG_V6];
      r_verd.collector_name_length = clen_nxt;
      r_verd.router_name_length    = rlen_nxt;
    end

    r0    = emit ? r_byte : r_verd;
    r1    = r_verd;
    npush = acc ? ({1'b0, emit} + {1'b0, eob}) : 2'd0;
  end

  // queue: drop head on pop, append new results behind what is left
  always_comb begin
    q_sh[0] = q_r[1];
    q_sh[1] = q_r[2];
    q_sh[2] = q_r[2];
    base    = cnt_r - {1'b0, pop};
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < base) begin
        q_nxt[i] = pop ? q_sh[i] : q_r[i];
      end else if ((2'(i) - base) < npush) begin
        q_nxt[i] = (2'(i) == base) ? r0 : r1;
      end else begin
        q_nxt[i] = q_r[i];
      end
    end
    cnt_nxt = base + npush;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 2'd0;
      phase_r <= bep_pkg::PH_START;
      fc_r    <= 16'd0;
      off_r   <= 18'd0;
      nl_r    <= 2'd0;
      hf_r    <= 8'd0;
      sec_r   <= 32'd0;
      usec_r  <= 32'd0;
      clen_r  <= 16'd0;
      rlen_r  <= 16'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (acc) begin
        if (eob) begin
          // buffer done: back to the start for the next one
          phase_r <= bep_pkg::PH_START;
          fc_r    <= 16'd0;
          off_r   <= 18'd0;
          nl_r    <= 2'd0;
          hf_r    <= 8'd0;
          sec_r   <= 32'd0;
          usec_r  <= 32'd0;
          clen_r  <= 16'd0;
          rlen_r  <= 16'd0;
        end else begin
          phase_r <= phase_nxt;
          fc_r    <= fc_nxt;
          off_r   <= off_nxt;
          nl_r    <= nl_nxt;
          hf_r    <= hf_nxt;
          sec_r   <= sec_nxt;
          usec_r  <= usec_nxt;
          clen_r  <= clen_nxt;
          rlen_r  <= rlen_nxt;
        end
      end
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign out_if.valid                 = (cnt_r != 2'd0);
  assign out_if.result_kind           = q_r[0].result_kind;
  assign out_if.out_byte              = q_r[0].out_byte;
  assign out_if.verdict               = q_r[0].verdict;
  assign out_if.header_length         = q_r[0].header_length;
  assign out_if.time_seconds          = q_r[0].time_seconds;
  assign out_if.time_microseconds     = q_r[0].time_microseconds;
  assign out_if.router_is_ipv6        = q_r[0].router_is_ipv6;
  assign out_if.collector_name_length = q_r[0].collector_name_length;
  assign out_if.router_name_length    = q_r[0].router_name_length;
  assign out_if.last_of_run           = q_r[0].last_of_run;

  // a byte is only taken while the queue has room for two results
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> cnt_r <= 2'd1)
    else $error("byte accepted with result queue too full");

  // the last byte of a buffer leaves the parser at its start state
  a_buf_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && eob) |=> (phase_r == bep_pkg::PH_START && off_r == 18'd0 && fc_r == 16'd0))
    else $error("parse state not cleared after end of buffer");

  // a verdict always closes the run of its byte
  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.result_kind == bep_pkg::KIND_VERDICT) |-> out_if.last_of_run)
    else $error("verdict not marked last of run");

  // phase stays within the defined codes, newline run never passes two
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r <= bep_pkg::PH_UNWANTED) && (nl_r <= 2'd2))
    else $error("parse phase or newline run out of range");

  // header values are only reported on a kept verdict
  a_info_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.verdict != bep_pkg::VERDICT_KEPT)
      |-> (out_if.collector_name_length == 16'd0 && out_if.router_is_ipv6 == 1'b0))
    else $error("header values on a result other than a kept verdict");

endmodule

// File: verif/testbench.sv
// testbench: self-checking bench for bmp_envelope_header_parser_top, byte stream in, results out
// depends on bep_pkg (hw/rtl/bep_pkg.sv) and bep_in_if / bep_out_if (hw/rtl/bep_channel_if.sv)
// predicts every result from the accepted bytes and checks them in order, with random idling
module testbench;

  localparam int CYCLE_LIMIT = 250_000;
  localparam int TAIL_CYCLES = 20;
  localparam int RANDOM_ITEMS = 1000;
  localparam logic [17:0] SHORT_BUF = 18'd4;

  // one pending input request and how the driver treats it
  typedef struct {
    logic [7:0] data;
    logic       eob;
    logic       drain;  // hold until every expected result has come
    logic       calm;   // no idling from here on
  } feed_t;

  logic clk;
  logic rst_n;

  bep_in_if  in_if();
  bep_out_if out_if();

  bmp_envelope_header_parser_top u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  feed_t            feed_q[$];
  bep_pkg::result_t expected_q[$];

  int  mismatches = 0;
  int  item_total = 0;
  int  cycles = 0;
  int  verdict_seen[5];
  int  name_bytes_seen = 0;
  logic tail_quiet = 1'b0;

  // ---------------------------------------------------------------------------
  // envelope predictor: its own copy of the parse state
  // ---------------------------------------------------------------------------
  logic [4:0]  ph;
  logic [15:0] fld_cnt;
  logic [17:0] hdr_off;
  logic [1:0]  nl_count;
  logic [7:0]  hdr_flags;
  logic [31:0] ts_sec;
  logic [31:0] ts_usec;
  logic [15:0] cname_len;
  logic [15:0] rname_len;
  logic        decided;

  function automatic void clear_parse();
    ph = bep_pkg::PH_START;
    fld_cnt = '0;
    hdr_off = '0;
    nl_count = '0;
    hdr_flags = '0;
    ts_sec = '0;
    ts_usec = '0;
    cname_len = '0;
    rname_len = '0;
    decided = 1'b0;
  endfunction

  // number of bytes in the current header field
  function automatic logic [15:0] field_span();
    case (ph)
      bep_pkg::PH_MAGIC: return 16'd4;
      bep_pkg::PH_VER:   return 16'd2;
      bep_pkg::PH_SKIP:  return 16'd6;
      bep_pkg::PH_FLAGS: return 16'd1;
      bep_pkg::PH_TYPE:  return 16'd1;
      bep_pkg::PH_SEC:   return 16'd4;
      bep_pkg::PH_USEC:  return 16'd4;
      bep_pkg::PH_CHASH: return bep_pkg::HASH_LEN;
      bep_pkg::PH_CLEN:  return 16'd2;
      bep_pkg::PH_CNAME: return cname_len;
      bep_pkg::PH_RHASH: return bep_pkg::HASH_LEN;
      bep_pkg::PH_RADDR: return bep_pkg::ADDR_LEN;
      bep_pkg::PH_RLEN:  return 16'd2;
      bep_pkg::PH_RNAME: return rname_len;
      default:           return 16'd4;
    endcase
  endfunction

  // count one byte of the field, move to the next field when it is full
  function automatic void step_field();
    fld_cnt = fld_cnt + 16'd1;
    if (fld_cnt < field_span()) return;
    fld_cnt = '0;
    if (ph == bep_pkg::PH_ROWS) begin
      ph = bep_pkg::PH_KEPT;
      decided = 1'b1;
      return;
    end
    ph = ph + 5'd1;
    // empty names are skipped over
    if (ph == bep_pkg::PH_CNAME && cname_len == 16'd0) ph = bep_pkg::PH_RHASH;
    if (ph == bep_pkg::PH_RNAME && rname_len == 16'd0) ph = bep_pkg::PH_ROWS;
  endfunction

  function automatic bep_pkg::result_t make_result(logic [1:0] kind, logic [7:0] b,
                                                   logic [2:0] v, logic [17:0] hl,
                                                   logic info);
    bep_pkg::result_t r;
    r = '0;
    r.result_kind = kind;
    r.out_byte = b;
    r.verdict = v;
    r.header_length = hl;
    if (info) begin
      r.time_seconds = ts_sec;
      r.time_microseconds = ts_usec;
      r.router_is_ipv6 = hdr_flags[bep_pkg::FLAG_V6];
      r.collector_name_length = cname_len;
      r.router_name_length = rname_len;
    end
    return r;
  endfunction

  // one accepted byte: update the parse state and queue the results it causes
  task automatic parse_byte(input logic [7:0] b, input logic eob);
    logic [17:0]      start_off;
    logic [15:0]      k;
    logic [2:0]       v;
    logic [17:0]      hl;
    logic             info;
    bep_pkg::result_t step_res[$];
    start_off = hdr_off;
    k = fld_cnt;
    // offset freezes once decided, except that unwanted counts the whole buffer
    if (!(decided && ph != bep_pkg::PH_UNWANTED) && hdr_off < bep_pkg::OFF_MAX)
      hdr_off = hdr_off + 18'd1;
    if (!decided) begin
      case (ph)
        bep_pkg::PH_START: begin
          if (b == bep_pkg::CHAR_V) begin
            ph = bep_pkg::PH_TEXT;
            nl_count = '0;
          end else if (b == bep_pkg::MAGIC[0]) begin
            ph = bep_pkg::PH_MAGIC;
            fld_cnt = 16'd1;
          end else begin
            ph = bep_pkg::PH_RAW;
            decided = 1'b1;
          end
        end
        bep_pkg::PH_TEXT: begin
          // the byte after two newlines closes the text header
          if (nl_count >= 2'd2) begin
            ph = bep_pkg::PH_TEXTDONE;
            decided = 1'b1;
            hdr_off = start_off;
          end else begin
            nl_count = (b == bep_pkg::CHAR_NL) ? nl_count + 2'd1 : 2'd0;
          end
        end
        bep_pkg::PH_MAGIC: begin
          if (b != bep_pkg::MAGIC[k[1:0]]) begin
            ph = bep_pkg::PH_RAW;
            decided = 1'b1;
          end else begin
            step_field();
          end
        end
        bep_pkg::PH_VER: begin
          if (k == 16'd0) begin
            hdr_flags = b;
            step_field();
          end else if (hdr_flags != bep_pkg::VER_MAJOR || b != bep_pkg::VER_MINOR) begin
            ph = bep_pkg::PH_UNWANTED;
            decided = 1'b1;
          end else begin
            hdr_flags = '0;
            step_field();
          end
        end
        bep_pkg::PH_FLAGS: begin
          hdr_flags = b;
          if (!b[bep_pkg::FLAG_ROUTER]) begin
            ph = bep_pkg::PH_UNWANTED;
            decided = 1'b1;
          end else begin
            step_field();
          end
        end
        bep_pkg::PH_TYPE: begin
          if (b != bep_pkg::OBJ_TYPE) begin
            ph = bep_pkg::PH_UNWANTED;
            decided = 1'b1;
          end else begin
            step_field();
          end
        end
        bep_pkg::PH_SEC: begin
          ts_sec = {ts_sec[23:0], b};
          step_field();
        end
        bep_pkg::PH_USEC: begin
          ts_usec = {ts_usec[23:0], b};
          step_field();
        end
        bep_pkg::PH_CLEN: begin
          cname_len = {cname_len[7:0], b};
          step_field();
        end
        bep_pkg::PH_RLEN: begin
          rname_len = {rname_len[7:0], b};
          step_field();
        end
        bep_pkg::PH_CNAME: begin
          if (k < bep_pkg::NAME_KEEP)
            step_res.push_back(make_result(bep_pkg::KIND_CNAME, b, '0, '0, 1'b0));
          step_field();
        end
        bep_pkg::PH_RNAME: begin
          if (k < bep_pkg::NAME_KEEP)
            step_res.push_back(make_result(bep_pkg::KIND_RNAME, b, '0, '0, 1'b0));
          step_field();
        end
        bep_pkg::PH_RADDR: begin
          // ipv4 routers report only the first four address bytes
          if (hdr_flags[bep_pkg::FLAG_V6] || k < bep_pkg::ADDR_V4_LEN)
            step_res.push_back(make_result(bep_pkg::KIND_RADDR, b, '0, '0, 1'b0));
          step_field();
        end
        default: begin
          step_field();
        end
      endcase
    end
    if (eob) begin
      v = bep_pkg::VERDICT_TRUNC;
      hl = '0;
      info = 1'b0;
      if (hdr_off < SHORT_BUF) begin
        v = bep_pkg::VERDICT_RAW;
      end else if (ph == bep_pkg::PH_RAW || ph == bep_pkg::PH_TEXT ||
                   ph == bep_pkg::PH_START) begin
        v = bep_pkg::VERDICT_RAW;
      end else if (ph == bep_pkg::PH_TEXTDONE) begin
        v = bep_pkg::VERDICT_TEXT;
        hl = hdr_off;
      end else if (ph == bep_pkg::PH_KEPT) begin
        v = bep_pkg::VERDICT_KEPT;
        hl = hdr_off;
        info = 1'b1;
      end else if (ph == bep_pkg::PH_UNWANTED) begin
        v = bep_pkg::VERDICT_UNWANTED;
        hl = hdr_off;
      end
      step_res.push_back(make_result(bep_pkg::KIND_VERDICT, '0, v, hl, info));
      clear_parse();
    end
    if (step_res.size() != 0) step_res[step_res.size() - 1].last_of_run = 1'b1;
    foreach (step_res[i]) expected_q.push_back(step_res[i]);
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result(bep_pkg::result_t want, bep_pkg::result_t got);
    check_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
    check_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
    check_field("verdict", 32'(want.verdict), 32'(got.verdict));
    check_field("header_length", 32'(want.header_length), 32'(got.header_length));
    check_field("time_seconds", want.time_seconds, got.time_seconds);
    check_field("time_microseconds", want.time_microseconds, got.time_microseconds);
    check_field("router_is_ipv6", 32'(want.router_is_ipv6), 32'(got.router_is_ipv6));
    check_field("collector_name_length", 32'(want.collector_name_length),
                32'(got.collector_name_length));
    check_field("router_name_length", 32'(want.router_name_length),
                32'(got.router_name_length));
    check_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
  endfunction

  // ---------------------------------------------------------------------------
  // buffer generation
  // ---------------------------------------------------------------------------
  function automatic void put_byte(ref logic [7:0] fr[$], input logic [7:0] b, input int limit);
    if (fr.size() < limit) fr.push_back(b);
  endfunction

  function automatic logic [7:0] other_than(logic [7:0] x);
    logic [7:0] r;
    do r = 8'($urandom); while (r == x);
    return r;
  endfunction

  // timestamps: mostly random, sometimes all zeros or all ones
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // name lengths: mostly short, some around the truncation point, rarely huge
  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8) return 16'($urandom_range(0, 4));
    if (r < 14) return 16'($urandom_range(5, 12));
    if (r < 17) return 16'($urandom_range(30, 33));
    if (r < 19) return 16'($urandom_range(34, 70));
    return ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom);
  endfunction

  // binary envelope, cut off at limit bytes; payload fills up to limit
  task automatic build_binary(ref logic [7:0] fr[$], input logic [7:0] major, minor, flags,
                              otype, input logic [15:0] clen, rlen, input int limit);
    logic [31:0] sec;
    logic [31:0] usec;
    int i;
    sec = pick_word();
    usec = pick_word();
    for (i = 0; i < 4; i++) put_byte(fr, bep_pkg::MAGIC[i], limit);
    put_byte(fr, major, limit);
    put_byte(fr, minor, limit);
    repeat (6) put_byte(fr, 8'($urandom), limit);
    put_byte(fr, flags, limit);
    put_byte(fr, otype, limit);
    for (i = 3; i >= 0; i--) put_byte(fr, sec[8*i +: 8], limit);
    for (i = 3; i >= 0; i--) put_byte(fr, usec[8*i +: 8], limit);
    repeat (16) put_byte(fr, 8'($urandom), limit);
    put_byte(fr, clen[15:8], limit);
    put_byte(fr, clen[7:0], limit);
    for (i = 0; i < clen && fr.size() < limit; i++) fr.push_back(8'($urandom));
    repeat (32) put_byte(fr, 8'($urandom), limit);
    put_byte(fr, rlen[15:8], limit);
    put_byte(fr, rlen[7:0], limit);
    for (i = 0; i < rlen && fr.size() < limit; i++) fr.push_back(8'($urandom));
    repeat (4) put_byte(fr, 8'($urandom), limit);
    while (fr.size() < limit) fr.push_back(8'($urandom));
  endtask

  task automatic queue_buffer(ref logic [7:0] fr[$], input logic drain, input logic calm);
    feed_t f;
    foreach (fr[i]) begin
      f.data = fr[i];
      f.eob = (i == fr.size() - 1);
      f.drain = drain && (i == 0);
      f.calm = calm;
      feed_q.push_back(f);
    end
    item_total += fr.size();
  endtask

  task automatic add_random_buffer(input logic drain, input logic calm);
    logic [7:0]  fr[$];
    logic [7:0]  major, minor, flags, otype;
    logic [15:0] clen, rlen;
    int pick, full, limit, fault, n;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      // binary envelope, a few with one failed check
      major = bep_pkg::VER_MAJOR;
      minor = bep_pkg::VER_MINOR;
      otype = bep_pkg::OBJ_TYPE;
      flags = 8'($urandom) | 8'h80;
      clen = pick_len();
      rlen = pick_len();
      full = 78 + clen + rlen + $urandom_range(0, 6);
      fault = (pick >= 45) ? $urandom_range(1, 5) : 0;
      case (fault)
        1: major = other_than(bep_pkg::VER_MAJOR);
        2: minor = other_than(bep_pkg::VER_MINOR);
        3: flags[bep_pkg::FLAG_ROUTER] = 1'b0;
        4: otype = other_than(bep_pkg::OBJ_TYPE);
        default: ;
      endcase
      if (clen > 100 || rlen > 100) limit = $urandom_range(20, 200);
      else if ($urandom_range(0, 3) == 0) limit = $urandom_range(1, full - 1);
      else limit = full;
      build_binary(fr, major, minor, flags, otype, clen, rlen, limit);
      if (fault == 5) begin
        n = $urandom_range(1, 3);
        if (n < fr.size()) fr[n] = other_than(bep_pkg::MAGIC[n]);
      end
    end else if (pick < 75) begin
      // text envelope, newlines frequent, sometimes never closed
      fr.push_back(bep_pkg::CHAR_V);
      repeat ($urandom_range(0, 20))
        fr.push_back(($urandom_range(0, 3) == 0) ? bep_pkg::CHAR_NL : 8'($urandom));
      if ($urandom_range(0, 6) != 0) begin
        fr.push_back(bep_pkg::CHAR_NL);
        fr.push_back(bep_pkg::CHAR_NL);
      end
      repeat ($urandom_range(0, 5)) fr.push_back(8'($urandom));
    end else if (pick < 87) begin
      repeat ($urandom_range(1, 12)) fr.push_back(8'($urandom));
    end else begin
      // noise that often starts like an envelope
      case ($urandom_range(0, 2))
        0: fr.push_back(bep_pkg::MAGIC[0]);
        1: fr.push_back(bep_pkg::CHAR_V);
        default: fr.push_back(8'($urandom));
      endcase
      repeat ($urandom_range(0, 19)) fr.push_back(8'($urandom));
    end
    queue_buffer(fr, drain, calm);
  endtask

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // driver: presents feed_q in order, idles in bursts, holds a request until taken
  // ---------------------------------------------------------------------------
  int gap_left = 0;

  always @(posedge clk) begin : drive
    logic fire;
    logic show;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.in_byte <= '0;
      in_if.end_of_buffer <= 1'b0;
      gap_left = 0;
    end else begin
      fire = in_if.valid && in_if.ready;
      if (fire) feed_q.delete(0);
      show = 1'b0;
      if (in_if.valid && !fire) begin
        // a request stays up until it is accepted
        show = 1'b1;
      end else if (feed_q.size() != 0) begin
        if (feed_q[0].calm) tail_quiet = 1'b1;
        if (gap_left != 0) begin
          gap_left--;
        end else if (!tail_quiet && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(0, 11);
        end else if (feed_q[0].drain && (fire || expected_q.size() != 0)) begin
          // pause until the block has emptied out
        end else begin
          show = 1'b1;
        end
      end
      in_if.valid <= show;
      if (show) begin
        in_if.in_byte <= feed_q[0].data;
        in_if.end_of_buffer <= feed_q[0].eob;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts from accepted bytes, checks accepted results, stalls ready
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin : watch
    bep_pkg::result_t want;
    bep_pkg::result_t got;
    logic             rdy;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (in_if.valid && in_if.ready) parse_byte(in_if.in_byte, in_if.end_of_buffer);
      if (out_if.valid && out_if.ready) begin
        got.result_kind = out_if.result_kind;
        got.out_byte = out_if.out_byte;
        got.verdict = out_if.verdict;
        got.header_length = out_if.header_length;
        got.time_seconds = out_if.time_seconds;
        got.time_microseconds = out_if.time_microseconds;
        got.router_is_ipv6 = out_if.router_is_ipv6;
        got.collector_name_length = out_if.collector_name_length;
        got.router_name_length = out_if.router_name_length;
        got.last_of_run = out_if.last_of_run;
        if (expected_q.size() == 0) begin
          $error("unexpected result: kind %0d byte 0x%0h verdict %0d",
                 got.result_kind, got.out_byte, got.verdict);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_result(want, got);
        end
        if (got.result_kind == bep_pkg::KIND_VERDICT) begin
          if (got.verdict <= bep_pkg::VERDICT_TRUNC) verdict_seen[got.verdict]++;
        end else begin
          name_bytes_seen++;
        end
      end
      // result side stalls in bursts too
      if (stall_left != 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (!tail_quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 11);
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_if.ready <= rdy;
    end
  end

  // ---------------------------------------------------------------------------
  // reset, stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0] fr[$];
    rst_n = 1'b0;
    clear_parse();

    // directed: tiny buffers, unknown first byte, text edge cases, bad and bare magic
    fr = '{8'h00};
    queue_buffer(fr, 1'b0, 1'b0);
    fr = '{bep_pkg::CHAR_V, bep_pkg::CHAR_NL, bep_pkg::CHAR_NL};
    queue_buffer(fr, 1'b0, 1'b0);
    fr = '{bep_pkg::MAGIC[0], bep_pkg::MAGIC[1], bep_pkg::MAGIC[2]};
    queue_buffer(fr, 1'b0, 1'b0);
    fr = '{8'hFF, 8'h55, 8'hAA, 8'h00};
    queue_buffer(fr, 1'b0, 1'b0);
    fr = '{bep_pkg::CHAR_V, bep_pkg::CHAR_NL, bep_pkg::CHAR_NL, 8'hFF};
    queue_buffer(fr, 1'b0, 1'b0);
    fr = '{bep_pkg::CHAR_V, 8'h41, bep_pkg::CHAR_NL, bep_pkg::CHAR_NL, bep_pkg::CHAR_NL,
           8'h42};
    queue_buffer(fr, 1'b0, 1'b0);
    fr = '{bep_pkg::MAGIC[0], bep_pkg::MAGIC[1], bep_pkg::MAGIC[2], 8'h58};
    queue_buffer(fr, 1'b0, 1'b0);
    fr = '{bep_pkg::MAGIC[0], bep_pkg::MAGIC[1], bep_pkg::MAGIC[2], bep_pkg::MAGIC[3]};
    queue_buffer(fr, 1'b0, 1'b0);

    // random buffers, the first one after a full drain, some more later
    add_random_buffer(1'b1, 1'b0);
    while (item_total < RANDOM_ITEMS) add_random_buffer($urandom_range(0, 19) == 0, 1'b0);

    // closing stretch with no idling on either side
    repeat (4) add_random_buffer(1'b0, 1'b1);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (feed_q.size() != 0) @(posedge clk);
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_q.size());
      mismatches++;
    end

    $display("summary: %0d bytes sent; verdicts raw %0d, text %0d, kept %0d, unwanted %0d,",
             item_total, verdict_seen[bep_pkg::VERDICT_RAW],
             verdict_seen[bep_pkg::VERDICT_TEXT], verdict_seen[bep_pkg::VERDICT_KEPT],
             verdict_seen[bep_pkg::VERDICT_UNWANTED]);
    $display("summary: truncated %0d; %0d name and address bytes checked",
             verdict_seen[bep_pkg::VERDICT_TRUNC], name_bytes_seen);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
